@@ hw/rtl/lpd_pkg.sv @@
`timescale 1ns / 1ps

package lpd_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam int PKT_LIMIT_TOTAL  = 30000;
	localparam int PKT_LIMIT_MARGIN = 1000;

	localparam logic [4:0]  HEADER_LEN_RST     = 5'd8;
	localparam logic [3:0]  LENGTH_OFFSET_RST  = 4'd0;
	localparam logic [15:0] MAX_PACKET_LEN_RST = 16'(PKT_LIMIT_TOTAL - PKT_LIMIT_MARGIN);

	typedef enum logic [1:0] {
		ST_PROGRESS = 2'd0,
		ST_ACCEPT   = 2'd1,
		ST_COMPLETE = 2'd2,
		ST_REJECT   = 2'd3
	} status_t;

	typedef enum logic {
		KIND_HEADER = 1'b0,
		KIND_BODY   = 1'b1
	} kind_t;

	typedef struct packed {
		logic [4:0]  header_len;
		logic [3:0]  length_offset;
		logic [15:0] max_packet_len;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  echo_byte;
		kind_t       byte_kind;
		status_t     frame_status;
		logic [15:0] packet_length;
	} res_t;

endpackage

@@ hw/rtl/lpd_regs.sv @@
`timescale 1ns / 1ps

module lpd_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output lpd_pkg::cfg_t      cfg
);
	import lpd_pkg::*;

	localparam logic [1:0] REG_HEADER_LEN     = 2'd0;
	localparam logic [1:0] REG_LENGTH_OFFSET  = 2'd1;
	localparam logic [1:0] REG_MAX_PACKET_LEN = 2'd2;

	logic [1:0] reg_idx;
	logic       wr_en;
	cfg_t       cfg_q;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_len     <= HEADER_LEN_RST;
			cfg_q.length_offset  <= LENGTH_OFFSET_RST;
			cfg_q.max_packet_len <= MAX_PACKET_LEN_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_HEADER_LEN:     cfg_q.header_len     <= pwdata[4:0];
				REG_LENGTH_OFFSET:  cfg_q.length_offset  <= pwdata[3:0];
				REG_MAX_PACKET_LEN: cfg_q.max_packet_len <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_HEADER_LEN:     prdata = 32'(cfg_q.header_len);
			REG_LENGTH_OFFSET:  prdata = 32'(cfg_q.length_offset);
			REG_MAX_PACKET_LEN: prdata = 32'(cfg_q.max_packet_len);
			default:            prdata = '0;
		endcase
	end

endmodule

@@ hw/rtl/lpd_front.sv @@
`timescale 1ns / 1ps

module lpd_front #(
	parameter int MAX_HEADER_BYTES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lpd_pkg::cfg_t cfg,
	input  logic          accept,
	input  logic [7:0]    rx_byte,
	output lpd_pkg::res_t res
);
	import lpd_pkg::*;

	localparam int HSW = (MAX_HEADER_BYTES > 2) ? $clog2(MAX_HEADER_BYTES) : 1;
	localparam int HCW = $clog2(MAX_HEADER_BYTES + 1);
	localparam int CW  = ((HCW > 5) ? HCW : 5) + 1;
	localparam logic [CW-1:0] HL_MIN = CW'(2);
	localparam logic [CW-1:0] HL_MAX = CW'(MAX_HEADER_BYTES);

	logic            in_body_q;
	logic [HSW-1:0]  header_count_q;
	logic [15:0]     length_capture_q;
	logic [15:0]     body_remaining_q;

	logic            in_body_d;
	logic [HSW-1:0]  header_count_d;
	logic [15:0]     length_capture_d;
	logic [15:0]     body_remaining_d;

	logic [CW-1:0]   hdr_len_w;
	logic [CW-1:0]   hl;
	logic [CW-1:0]   cnt_w;
	logic [CW-1:0]   cnt_inc;
	logic [CW-1:0]   off_w;
	logic [CW-1:0]   off_inc;
	logic [15:0]     hl16;

	always_comb begin
		hdr_len_w = CW'(cfg.header_len);
		if (hdr_len_w < HL_MIN) begin
			hl = HL_MIN;
		end else if (hdr_len_w > HL_MAX) begin
			hl = HL_MAX;
		end else begin
			hl = hdr_len_w;
		end
		hl16    = 16'(hl);
		cnt_w   = CW'(header_count_q);
		cnt_inc = cnt_w + CW'(1);
		off_w   = CW'(cfg.length_offset);
		off_inc = off_w + CW'(1);

		in_body_d        = in_body_q;
		header_count_d   = header_count_q;
		length_capture_d = length_capture_q;
		body_remaining_d = body_remaining_q;

		res.echo_byte     = rx_byte;
		res.byte_kind     = KIND_HEADER;
		res.frame_status  = ST_PROGRESS;
		res.packet_length = '0;

		if (in_body_q) begin
			res.byte_kind = KIND_BODY;
			if (body_remaining_q <= 16'd1) begin
				res.frame_status = ST_COMPLETE;
				in_body_d        = 1'b0;
				header_count_d   = '0;
				body_remaining_d = '0;
			end else begin
				body_remaining_d = body_remaining_q - 16'd1;
			end
		end else begin
			if (header_count_q == '0) begin
				length_capture_d = '0;
			end
			if (cnt_w < hl) begin
				if (cnt_w == off_w) begin
					length_capture_d[15:8] = rx_byte;
				end else if (cnt_w == off_inc) begin
					length_capture_d[7:0] = rx_byte;
				end
			end
			header_count_d = HSW'(cnt_inc);
			if (cnt_inc >= hl) begin
				res.packet_length = length_capture_d;
				header_count_d    = '0;
				if (length_capture_d < hl16 || length_capture_d > cfg.max_packet_len) begin
					res.frame_status = ST_REJECT;
					body_remaining_d = '0;
				end else if (length_capture_d == hl16) begin
					res.frame_status = ST_COMPLETE;
					body_remaining_d = '0;
				end else begin
					res.frame_status = ST_ACCEPT;
					in_body_d        = 1'b1;
					body_remaining_d = length_capture_d - hl16;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q        <= 1'b0;
			header_count_q   <= '0;
			length_capture_q <= '0;
			body_remaining_q <= '0;
		end else if (accept) begin
			in_body_q        <= in_body_d;
			header_count_q   <= header_count_d;
			length_capture_q <= length_capture_d;
			body_remaining_q <= body_remaining_d;
		end
	end

	a_body_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> header_count_q == '0)
		else $error("header count not cleared in body");

	a_body_entry_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_body_q) |-> body_remaining_q != 16'd0)
		else $error("body entered with nothing left to count");

endmodule

@@ hw/rtl/lpd_queue.sv @@
`timescale 1ns / 1ps

module lpd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  lpd_pkg::res_t wdata,
	output logic          full,
	input  logic          rd,
	output logic          not_empty,
	output lpd_pkg::res_t rdata
);
	import lpd_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	res_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [NW-1:0] count_q;

	assign full      = (count_q == NW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + PW'(1);
			end
			if (rd) begin
				rptr_q <= rptr_q + PW'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + NW'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(QUEUE_DEPTH))
		else $error("queue count past depth");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> !full)
		else $error("write into full queue");

endmodule

@@ hw/rtl/lpd_back.sv @@
`timescale 1ns / 1ps

module lpd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_not_empty,
	input  lpd_pkg::res_t q_rdata,
	output logic          q_rd,
	output logic          empty,
	input  logic          pop,
	output lpd_pkg::res_t out
);
	import lpd_pkg::*;

	logic out_valid_q;
	res_t out_q;

	assign q_rd  = q_not_empty && (!out_valid_q || pop);
	assign empty = !out_valid_q;
	assign out   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_rd) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			out_q <= q_rdata;
		end
	end

endmodule

@@ hw/rtl/length_prefixed_packet_deframer_top.sv @@
`timescale 1ns / 1ps

// channel   direction  handshake                       payload
// config    in         psel/penable/pwrite, pready=1   paddr, pwdata, prdata
// rx item   in         push & !full                    rx_byte
// result    out        pop & !empty                    echo_byte, byte_kind,
//                                                      frame_status, packet_length
//
// one item per cycle sustained while full is low; the front writes its result into the queue at
// accept, and the output register loads it from there when it is free or being popped
// reset clears framing state, queue and output valid flag; registers return to defaults
// a four-entry queue plus the output register absorb result stalls; full is high
// whenever the queue holds four items, a pop in that cycle frees a slot for the next one

module length_prefixed_packet_deframer_top #(
	parameter int MAX_HEADER_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  echo_byte,
	output logic        byte_kind,
	output logic [1:0]  frame_status,
	output logic [15:0] packet_length
);
	import lpd_pkg::*;

	cfg_t cfg;
	res_t front_res;
	res_t q_rdata;
	res_t out;
	logic accept;
	logic q_full;
	logic q_not_empty;
	logic q_rd;

	assign full   = q_full;
	assign accept = push && !q_full;

	lpd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lpd_front #(
		.MAX_HEADER_BYTES (MAX_HEADER_BYTES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.accept  (accept),
		.rx_byte (rx_byte),
		.res     (front_res)
	);

	lpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (accept),
		.wdata     (front_res),
		.full      (q_full),
		.rd        (q_rd),
		.not_empty (q_not_empty),
		.rdata     (q_rdata)
	);

	lpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_rdata     (q_rdata),
		.q_rd        (q_rd),
		.empty       (empty),
		.pop         (pop),
		.out         (out)
	);

	assign echo_byte     = out.echo_byte;
	assign byte_kind     = out.byte_kind;
	assign frame_status  = out.frame_status;
	assign packet_length = out.packet_length;

endmodule

@@ test/lpd_frame_checker.sv @@
`timescale 1ns / 1ps

package lpd_regmap_pkg;

	typedef enum logic [3:0] {
		ADDR_HEADER_LEN     = 4'h0,
		ADDR_LENGTH_OFFSET  = 4'h4,
		ADDR_MAX_PACKET_LEN = 4'h8
	} reg_addr_t;

endpackage

module lpd_frame_checker
	import lpd_pkg::*;
	import lpd_regmap_pkg::*;
#(
	parameter int MAX_HEADER_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  rx_byte,
	input  logic        pop,
	input  logic        empty,
	input  logic [7:0]  echo_byte,
	input  logic        byte_kind,
	input  logic [1:0]  frame_status,
	input  logic [15:0] packet_length,
	output int          fail_count,
	output int          in_flight,
	output int          bytes_in,
	output int          results_seen,
	output int          packets_done,
	output int          headers_rejected,
	output int          body_bytes
);

	cfg_t        cfg;
	logic        in_body;
	int unsigned hdr_count;
	logic [15:0] len_capture;
	logic [15:0] body_left;
	res_t        expected_echoes[$];
	res_t        want;
	int          errs;
	int          n_in;
	int          n_out;
	int          n_done;
	int          n_rej;
	int          n_body;

	task automatic back_to_header();
		in_body   = 1'b0;
		hdr_count = 0;
		body_left = '0;
	endtask

	task automatic deframe_byte(input logic [7:0] b, output res_t r);
		int unsigned hl;
		logic [15:0] plen;
		hl = 32'(cfg.header_len);
		if (hl < 2)
			hl = 2;
		if (hl > MAX_HEADER_BYTES)
			hl = MAX_HEADER_BYTES;
		r.echo_byte     = b;
		r.byte_kind     = KIND_HEADER;
		r.frame_status  = ST_PROGRESS;
		r.packet_length = '0;
		if (in_body) begin
			r.byte_kind = KIND_BODY;
			if (body_left <= 16'd1) begin
				r.frame_status = ST_COMPLETE;
				back_to_header();
			end else begin
				body_left = body_left - 16'd1;
			end
		end else begin
			if (hdr_count == 0)
				len_capture = '0;
			if (hdr_count < hl) begin
				if (hdr_count == int'(cfg.length_offset))
					len_capture = {b, len_capture[7:0]};
				else if (hdr_count == int'(cfg.length_offset) + 1)
					len_capture = {len_capture[15:8], b};
			end
			hdr_count = (hdr_count + 1) & 63;
			if (hdr_count >= hl) begin
				plen = len_capture;
				r.packet_length = plen;
				if (plen < hl || plen > cfg.max_packet_len) begin
					r.frame_status = ST_REJECT;
					back_to_header();
				end else if (plen == hl) begin
					r.frame_status = ST_COMPLETE;
					back_to_header();
				end else begin
					r.frame_status = ST_ACCEPT;
					in_body   = 1'b1;
					hdr_count = 0;
					body_left = plen - 16'(hl);
				end
			end
		end
	endtask

	task automatic check_field(input string field, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			errs++;
			$error("%s: expected %0d, actual %0d", field, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.header_len     = HEADER_LEN_RST;
			cfg.length_offset  = LENGTH_OFFSET_RST;
			cfg.max_packet_len = MAX_PACKET_LEN_RST;
			in_body     = 1'b0;
			hdr_count   = 0;
			len_capture = '0;
			body_left   = '0;
			expected_echoes.delete();
			errs   = 0;
			n_in   = 0;
			n_out  = 0;
			n_done = 0;
			n_rej  = 0;
			n_body = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ADDR_HEADER_LEN:     cfg.header_len     = pwdata[4:0];
					ADDR_LENGTH_OFFSET:  cfg.length_offset  = pwdata[3:0];
					ADDR_MAX_PACKET_LEN: cfg.max_packet_len = pwdata[15:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (expected_echoes.size() == 0) begin
					errs++;
					$error("result with no item outstanding: echo_byte %0d", echo_byte);
				end else begin
					want = expected_echoes.pop_front();
					n_out++;
					check_field("echo_byte", 16'(want.echo_byte), 16'(echo_byte));
					check_field("byte_kind", 16'(want.byte_kind), 16'(byte_kind));
					check_field("frame_status", 16'(want.frame_status), 16'(frame_status));
					check_field("packet_length", want.packet_length, packet_length);
					if (want.frame_status == ST_COMPLETE)
						n_done++;
					if (want.frame_status == ST_REJECT)
						n_rej++;
					if (want.byte_kind == KIND_BODY)
						n_body++;
				end
			end
			if (push && !full) begin
				deframe_byte(rx_byte, want);
				expected_echoes.push_back(want);
				n_in++;
			end
		end
		fail_count       <= errs;
		in_flight        <= expected_echoes.size();
		bytes_in         <= n_in;
		results_seen     <= n_out;
		packets_done     <= n_done;
		headers_rejected <= n_rej;
		body_bytes       <= n_body;
	end

endmodule

@@ test/tb_length_prefixed_packet_deframer_top.sv @@
`timescale 1ns / 1ps

module tb_length_prefixed_packet_deframer_top;
	import lpd_pkg::*;
	import lpd_regmap_pkg::*;

	localparam int MAX_HDR = 16;
	localparam int PHASE_BYTES = 185;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [3:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic        push    = 1'b0;
	logic [7:0]  rx_byte = '0;
	logic        pop     = 1'b0;
	logic [31:0] prdata;
	logic        pready;
	logic        full;
	logic        empty;
	logic [7:0]  echo_byte;
	logic        byte_kind;
	logic [1:0]  frame_status;
	logic [15:0] packet_length;

	int fail_count;
	int in_flight;
	int bytes_in;
	int results_seen;
	int packets_done;
	int headers_rejected;
	int body_bytes;

	int send_idle = 0;
	int recv_idle = 0;
	int hdr_size  = 8;
	int len_off   = 0;
	int max_len   = 29000;
	int hdr_pos   = 0;
	int phase_bytes;

	always #5 clk = ~clk;

	length_prefixed_packet_deframer_top #(
		.MAX_HEADER_BYTES(MAX_HDR)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.push         (push),
		.full         (full),
		.rx_byte      (rx_byte),
		.empty        (empty),
		.pop          (pop),
		.echo_byte    (echo_byte),
		.byte_kind    (byte_kind),
		.frame_status (frame_status),
		.packet_length(packet_length)
	);

	lpd_frame_checker #(
		.MAX_HEADER_BYTES(MAX_HDR)
	) i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.push            (push),
		.full            (full),
		.rx_byte         (rx_byte),
		.pop             (pop),
		.empty           (empty),
		.echo_byte       (echo_byte),
		.byte_kind       (byte_kind),
		.frame_status    (frame_status),
		.packet_length   (packet_length),
		.fail_count      (fail_count),
		.in_flight       (in_flight),
		.bytes_in        (bytes_in),
		.results_seen    (results_seen),
		.packets_done    (packets_done),
		.headers_rejected(headers_rejected),
		.body_bytes      (body_bytes)
	);

	initial begin
		#8_000_000;
		$display("timeout: run did not finish");
		$display("status: fail");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic put_item(input logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		phase_bytes++;
	endtask

	task automatic write_reg(input reg_addr_t addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input int hl_raw, input int off, input int mx);
		write_reg(ADDR_HEADER_LEN, hl_raw);
		write_reg(ADDR_LENGTH_OFFSET, off);
		write_reg(ADDR_MAX_PACKET_LEN, mx);
		hdr_size = hl_raw < 2 ? 2 : (hl_raw > MAX_HDR ? MAX_HDR : hl_raw);
		len_off  = off;
		max_len  = mx;
	endtask

	// hold the sender until every result has been popped
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
	endtask

	// sends header bytes from the current header position, at most count of them
	task automatic put_header(input logic [15:0] len_field, input int count);
		logic [7:0] b;
		int n;
		n = 0;
		do begin
			if (hdr_pos == len_off)
				b = len_field[15:8];
			else if (hdr_pos == len_off + 1)
				b = len_field[7:0];
			else
				b = 8'($urandom_range(255));
			put_item(b);
			hdr_pos++;
			n++;
		end while (hdr_pos < hdr_size && n < count);
		if (hdr_pos >= hdr_size)
			hdr_pos = 0;
	endtask

	task automatic random_frame();
		int plen;
		int room;
		room = max_len - hdr_size;
		if (len_off + 1 >= hdr_size) begin
			// length field not fully inside the header, reads as zero
			put_header(16'h0000, MAX_HDR);
		end else if ($urandom_range(99) < 75 && room >= 0) begin
			if ($urandom_range(29) == 0)
				plen = hdr_size + $urandom_range(room < 300 ? room : 300);
			else
				plen = hdr_size + $urandom_range(room < 24 ? room : 24);
			put_header(16'(plen), MAX_HDR);
			repeat (plen - hdr_size)
				put_item(8'($urandom_range(255)));
		end else begin
			if (max_len < 65535 && $urandom_range(1))
				plen = $urandom_range(65535, max_len + 1);
			else
				plen = $urandom_range(hdr_size - 1);
			put_header(16'(plen), MAX_HDR);
		end
	endtask

	initial begin
		int cfg_hl[6];
		int cfg_off[6];
		int cfg_max[6];
		cfg_hl  = '{8, 0, 31, 16, 1, 5};
		cfg_off = '{0, 0, 14, 15, 3, 2};
		cfg_max = '{29000, 65535, 200, 0, 100, 65535};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: header-only, short, long, single and two-byte bodies
		send_idle = 37;
		recv_idle <= 45;
		set_config(3, 1, 6);
		put_item(8'hff); put_item(8'h00); put_item(8'h03);
		put_item(8'h00); put_item(8'h00); put_item(8'h02);
		put_item(8'hff); put_item(8'h00); put_item(8'h07);
		put_item(8'haa); put_item(8'h00); put_item(8'h05); put_item(8'hff); put_item(8'h00);
		put_item(8'h55); put_item(8'h00); put_item(8'h04); put_item(8'h80);
		drain();

		for (int p = 0; p < 6; p++) begin
			if (p < 2) begin
				send_idle = 37;
				recv_idle <= 45;
			end else if (p < 4) begin
				send_idle = 45;
				recv_idle <= 37;
			end else begin
				send_idle = 0;
				recv_idle <= 0;
			end
			set_config(cfg_hl[p], cfg_off[p], cfg_max[p]);
			// finish the header cut short before the register change
			if (hdr_pos != 0)
				put_header(16'h0000, MAX_HDR);
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES)
				random_frame();
			put_header(16'h0000, $urandom_range(hdr_size - 1, 1));
			drain();
		end

		repeat (8) @(posedge clk);
		$display("sent %0d bytes, checked %0d results: %0d packets complete, %0d headers rejected",
			bytes_in, results_seen, packets_done, headers_rejected);
		$display("%0d body bytes over six register settings, with headers cut short between them",
			body_bytes);
		if (in_flight != 0)
			$error("%0d expected results never arrived", in_flight);
		if (fail_count == 0 && in_flight == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/lpd_pkg.sv
hw/rtl/lpd_regs.sv
hw/rtl/lpd_front.sv
hw/rtl/lpd_queue.sv
hw/rtl/lpd_back.sv
hw/rtl/length_prefixed_packet_deframer_top.sv
test/lpd_frame_checker.sv
test/tb_length_prefixed_packet_deframer_top.sv
